@@ rtl/core/lruc_pkg.sv @@
// Package for the LRU key-value cache: field widths, command codes,
// the entry record passed along the cell chain and the cell control group.
// No dependencies.
package lruc_pkg;

  localparam int LRUC_ENTRIES = 16;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 31;
  localparam int CAP_W        = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Configuration register indexes.
  localparam logic REG_CAPACITY = 1'b0;

  // Command codes carried in in_tuser.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lruc_entry_t;

  typedef struct packed {
    logic cmp;   // latch the key compare
    logic take;  // load the neighbor's entry
  } lruc_cell_ctl_t;

endpackage

@@ rtl/core/lruc_cell.sv @@
// One cell of the recency-ordered chain: holds one entry, compares it with
// the request key and loads its more recent neighbor's entry on a shift.
// Depends on lruc_pkg.
module lruc_cell
  import lruc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lruc_cell_ctl_t   ctl,
  input  logic [KEY_W-1:0] req_key,
  input  lruc_entry_t      prev_entry,
  output lruc_entry_t      entry,
  output logic             match
);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.take) begin
        valid_r <= prev_entry.valid;
      end
      if (ctl.cmp) begin
        match_r <= valid_r && (key_r == req_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      key_r   <= prev_entry.key;
      value_r <= prev_entry.value;
    end
  end

  assign entry = '{valid: valid_r, key: key_r, value: value_r};
  assign match = match_r;

endmodule

@@ rtl/core/lruc_select.sv @@
// Reduction logic over the cell chain: hit position and value from the
// registered match vector, and the key of the least recent entry.
// Depends on lruc_pkg.
module lruc_select
  import lruc_pkg::*;
#(
  parameter int ENTRIES = LRUC_ENTRIES,
  parameter int IDX_W   = $clog2(ENTRIES),
  parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic [ENTRIES-1:0] match,
  input  lruc_entry_t        entries [ENTRIES],
  input  logic [CNT_W-1:0]   used,
  output logic               hit,
  output logic [IDX_W-1:0]   hit_idx,
  output logic [VAL_W-1:0]   hit_value,
  output logic [KEY_W-1:0]   last_key
);

  logic [CNT_W-1:0] last_pos;

  assign last_pos = used - CNT_W'(1);

  // Keys are unique among valid cells, so at most one match bit is set
  // and plain OR trees give the position and the value.
  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    hit_value = '0;
    last_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit       = 1'b1;
        hit_idx   = hit_idx | IDX_W'(i);
        hit_value = hit_value | entries[i].value;
      end
      if (CNT_W'(i) == last_pos) begin
        last_key = last_key | entries[i].key;
      end
    end
  end

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: stream ports, capacity register,
// control sequencer and the chain of entry cells.
// Depends on lruc_pkg, lruc_cell and lruc_select.
//
// The cache holds up to ENTRIES key-value pairs in a chain of cells kept in
// recency order: cell 0 holds the most recent entry and the valid cells
// always form an unbroken run from cell 0. Each input beat is a get or a put
// (in_tuser), with the key in in_tdata[31:0] and the value in in_tdata[62:32].
// Every beat yields exactly one result beat: out_tuser[0] is found,
// out_tuser[1] is evicted, out_tdata[30:0] is the value read on a get hit
// (zero otherwise) and out_tdata[62:31] the key of the entry that a put of a
// new key pushed out (zero otherwise). An item is accepted in S_IDLE, then
// in S_CMP all cells compare the key in parallel, in S_SEL the reductions
// find the hit position, the hit value and the least recent key, and in
// S_UPD the result is loaded into the output register while, when the chain
// shifts, every cell at or before the shift boundary loads its neighbor's
// entry. S_UPD waits only while the output register still holds an earlier
// result that has not been taken, and a new beat is accepted only in S_IDLE.
// The capacity register (address 0) limits how many entries may be in use
// before a new put evicts the least recent one; zero acts as one and values
// above ENTRIES act as ENTRIES. Lowering it does not drop entries at once:
// each later put of a new key replaces only the single least recent entry.
// The user must write capacity only while the cache is idle; the block does
// not enforce this. All cells are empty after reset; no clearing pass is needed.
module lru_key_value_cache
  import lruc_pkg::*;
#(
  parameter int ENTRIES = LRUC_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] key, [62:32] value, [63] zero
  input  logic        in_tuser,   // [0] cmd
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [30:0] read_value, [62:31] evicted_key, [63] zero
  output logic [1:0]  out_tuser,  // [0] found, [1] evicted
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SEL  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   used_r, used_nxt;

  // Request held for the duration of one item.
  logic               req_cmd_r;
  logic [KEY_W-1:0]   req_key_r;
  logic [VAL_W-1:0]   req_val_r;

  // Decisions taken in the select cycle.
  logic               found_r;
  logic               evict_r;
  logic               shift_r;
  logic               grow_r;
  logic [IDX_W-1:0]   bound_r;
  logic [VAL_W-1:0]   front_val_r;
  logic [VAL_W-1:0]   read_val_r;
  logic [KEY_W-1:0]   evict_key_r;

  // Output register.
  logic               out_valid_r;
  logic [63:0]        out_tdata_r;
  logic [1:0]         out_tuser_r;

  logic               in_fire;
  logic               upd_go;
  logic               cfg_wr;

  logic [ENTRIES-1:0] match;
  lruc_entry_t        entries [ENTRIES];
  lruc_entry_t        front_entry;
  lruc_cell_ctl_t     cell_ctl [ENTRIES];

  logic               sel_hit;
  logic [IDX_W-1:0]   sel_hit_idx;
  logic [VAL_W-1:0]   sel_hit_value;
  logic [KEY_W-1:0]   sel_last_key;

  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  logic               is_put;

  // ---------------------------------------------------------------------
  // Configuration port. Only the capacity register exists; writes to any
  // other word are ignored and read back as zero.
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_CAPACITY)) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_CAPACITY) begin
      cfg_prdata = {{(32 - CAP_W){1'b0}}, cap_r};
    end
  end

  // Effective capacity: zero acts as one, anything above ENTRIES as ENTRIES.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
  end

  assign full   = CMP_W'(used_r) >= cap_eff;
  assign is_put = (req_cmd_r == CMD_PUT);

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_UPD;
      S_UPD:   if (upd_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_cmd_r <= in_tuser;
      req_key_r <= in_tdata[KEY_W-1:0];
      req_val_r <= in_tdata[KEY_W +: VAL_W];
    end
  end

  // ---------------------------------------------------------------------
  // Select cycle: settle hit, eviction and how far the chain shifts.
  // A hit at position h moves that entry to the front and shifts cells
  // 1..h. A put of a new key shifts every valid cell and fills the next empty
  // one, or, when the cache is full, overwrites the least recent cell.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == S_SEL) begin
      found_r     <= sel_hit;
      evict_r     <= !sel_hit && is_put && full;
      shift_r     <= sel_hit || is_put;
      grow_r      <= !sel_hit && is_put && !full;
      read_val_r  <= (sel_hit && !is_put) ? sel_hit_value : '0;
      front_val_r <= is_put ? req_val_r : sel_hit_value;
      evict_key_r <= (!sel_hit && is_put && full) ? sel_last_key : '0;
      if (sel_hit) begin
        bound_r <= sel_hit_idx;
      end else if (full) begin
        bound_r <= IDX_W'(used_r - CNT_W'(1));
      end else begin
        bound_r <= IDX_W'(used_r);
      end
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (upd_go && grow_r) begin
      used_nxt = used_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: loaded in the update cycle, which waits for it.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_tdata_r <= {1'b0, evict_key_r, read_val_r};
      out_tuser_r <= {evict_r, found_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------
  // Cell chain.
  // ---------------------------------------------------------------------
  assign front_entry = '{valid: 1'b1, key: req_key_r, value: front_val_r};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign cell_ctl[i].cmp  = (state_r == S_CMP);
    assign cell_ctl[i].take = upd_go && shift_r && (IDX_W'(i) <= bound_r);

    lruc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl[i]),
      .req_key    (req_key_r),
      .prev_entry ((i == 0) ? front_entry : entries[(i == 0) ? 0 : i - 1]),
      .entry      (entries[i]),
      .match      (match[i])
    );
  end

  lruc_select #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_select (
    .match     (match),
    .entries   (entries),
    .used      (used_r),
    .hit       (sel_hit),
    .hit_idx   (sel_hit_idx),
    .hit_value (sel_hit_value),
    .last_key  (sel_last_key)
  );

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(ENTRIES))
    else $error("entry count exceeds the number of cells");

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL) |-> $onehot0(match))
    else $error("request key matched more than one cell");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && evict_r) |-> (used_r != '0) && !found_r)
    else $error("eviction without a stored entry or on a hit");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_tvalid && (state_r == S_IDLE))
    else $error("update cycle did not deliver a result");

  a_grow_step: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && grow_r) |=> used_r == $past(used_r) + CNT_W'(1))
    else $error("entry count did not follow an insert");

endmodule
